// ===== rtl/timing_wheel_timeout_table_macros.svh =====
// Assertion macros for the timing wheel timeout table.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef TIMING_WHEEL_TIMEOUT_TABLE_MACROS_SVH
`define TIMING_WHEEL_TIMEOUT_TABLE_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define TWTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true.
`define TWTT_ASSERT_NEVER(label, cond, msg) \
  `TWTT_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/twtt_pkg.sv =====
// Shared types, constants and helpers of the timing wheel timeout table.
// No dependencies; used by twtt_rem_unit and timing_wheel_timeout_table.
package twtt_pkg;

  localparam int TIMER_ENTRIES = 64;
  localparam int ID_W          = 6;
  localparam int DELAY_W       = 32;
  localparam int SLOT_W        = 7;
  localparam int CUR_W         = 6;
  localparam int ENTRY_CNT_W   = $clog2(TIMER_ENTRIES + 1);

  localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(60);
  localparam logic [SLOT_W-1:0] MAX_SLOTS  = SLOT_W'(64);

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_REFRESH = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay_ticks;
  } twtt_req_t;

  typedef struct packed {
    logic [ID_W-1:0] expired_id;
    logic            last_expired;
  } twtt_rsp_t;

  typedef struct packed {
    logic [CUR_W-1:0]  expiry;
    logic [SLOT_W-1:0] delay;
  } twtt_entry_t;

  typedef struct packed {
    logic               start;
    logic [DELAY_W-1:0] dividend;
  } twtt_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CUR_W-1:0] rem;
  } twtt_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RD,
    ST_DIV,
    ST_SCAN,
    ST_FLUSH
  } twtt_state_e;

  // Slot count as used by the wheel: zero acts as one, values above the maximum clamp.
  function automatic logic [SLOT_W-1:0] eff_slots(input logic [SLOT_W-1:0] raw);
    logic [SLOT_W-1:0] res;
    if (raw == '0) begin
      res = SLOT_W'(1);
    end else if (raw > MAX_SLOTS) begin
      res = MAX_SLOTS;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// ===== rtl/twtt_rem_unit.sv =====
// Bit-serial remainder unit: dividend modulo slot count, one dividend bit per cycle.
// Depends on twtt_pkg.
module twtt_rem_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  twtt_pkg::twtt_div_req_t      req_i,
  input  logic [twtt_pkg::SLOT_W-1:0]  divisor_i,
  output twtt_pkg::twtt_div_rsp_t      rsp_o
);

  localparam int CNT_W = $clog2(twtt_pkg::DELAY_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [twtt_pkg::DELAY_W-1:0]  dvd_q, dvd_d;
  logic [twtt_pkg::CUR_W-1:0]    rem_q, rem_d;
  logic [twtt_pkg::SLOT_W-1:0]   trial;

  // The partial remainder stays below the divisor, so it fits the slot index width.
  assign trial = {rem_q, dvd_q[twtt_pkg::DELAY_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= divisor_i) begin
        rem_d = twtt_pkg::CUR_W'(trial - divisor_i);
      end else begin
        rem_d = twtt_pkg::CUR_W'(trial);
      end
      dvd_d = {dvd_q[twtt_pkg::DELAY_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(twtt_pkg::DELAY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, rem: rem_q};

endmodule

// ===== rtl/timing_wheel_timeout_table.sv =====
// Top level of the timing wheel timeout table: command decode, entry memory and tick scan.
// Depends on twtt_pkg, twtt_rem_unit and timing_wheel_timeout_table_macros.svh.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   in_req_i  (cmd, timer_id, delay_ticks)
//   out      result     out_valid_o / out_stall_i out_rsp_o (expired_id, last_expired)
//   cfg      write      cfg_we_i                  cfg_wdata_i (wheel_slots)
//
// Steps per request: an add takes the request, the remainder steps, one per delay bit,
// and the write back; a refresh also takes the entry read; a tick takes the request,
// the entry reads, one a cycle unless a full output holds the scan, the last check, the
// drain and the flush; an ignored command takes only the request. A full output can also
// hold the flush. A wheel write stalls requests while the pointer is reduced. Reset clears
// the armed bits and the pointer at once; every entry is read, but only armed ones match.
`include "timing_wheel_timeout_table_macros.svh"

module timing_wheel_timeout_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  twtt_pkg::twtt_req_t          in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output twtt_pkg::twtt_rsp_t          out_rsp_o,
  input  logic                         cfg_we_i,
  input  logic [twtt_pkg::SLOT_W-1:0]  cfg_wdata_i
);

  localparam int ID_W  = twtt_pkg::ID_W;
  localparam int CUR_W = twtt_pkg::CUR_W;
  localparam int SW    = twtt_pkg::SLOT_W;
  localparam int ECW   = twtt_pkg::ENTRY_CNT_W;

  // Control and context registers.
  twtt_pkg::twtt_state_e              state_q, state_d;
  logic [SW-1:0]                      slots_q, slots_d;
  logic [CUR_W-1:0]                   cur_q, cur_d;
  logic [twtt_pkg::TIMER_ENTRIES-1:0] armed_q, armed_d;
  logic                               is_refresh_q, is_refresh_d;
  logic [ID_W-1:0]                    id_q, id_d;
  logic [SW-1:0]                      dly_q, dly_d;

  // Scan pipeline: issue index, the entry under check and the match held back for
  // its last flag.
  logic [ECW-1:0]                     issue_q, issue_d;
  logic                               chk_valid_q, chk_valid_d;
  logic [ID_W-1:0]                    chk_idx_q, chk_idx_d;
  logic                               pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]                    pend_id_q, pend_id_d;

  // Output register.
  logic                               out_valid_q, out_valid_d;
  twtt_pkg::twtt_rsp_t                out_rsp_q, out_rsp_d;

  // Entry memory, one synchronous read and one write port.
  twtt_pkg::twtt_entry_t              mem [twtt_pkg::TIMER_ENTRIES];
  logic                               mem_we, mem_re;
  logic [ID_W-1:0]                    mem_waddr, mem_raddr;
  twtt_pkg::twtt_entry_t              mem_wdata, rdata_q;

  twtt_pkg::twtt_div_req_t            div_req;
  twtt_pkg::twtt_div_rsp_t            div_rsp;

  logic [SW-1:0]                      sc;
  logic                               accept, id_ok, out_free;
  logic                               hit, blocked, scan_end;
  logic [SW-1:0]                      tick_next, add_d, add_sum;

  // State decodes used by the checks at the end.
  logic                               st_idle, st_tick, st_div, hit_taken;

  assign sc       = twtt_pkg::eff_slots(slots_q);
  assign accept   = in_valid_i && !in_stall_o;
  assign id_ok    = (ECW'(in_req_i.timer_id) < ECW'(twtt_pkg::TIMER_ENTRIES));
  assign out_free = !out_valid_q || !out_stall_i;

  // An entry under check matches when it is armed and its expiry slot is the pointer.
  assign hit      = chk_valid_q && armed_q[chk_idx_q] && (rdata_q.expiry == cur_q);
  // Two matches in hand and nowhere to put the older one: hold the scan.
  assign blocked  = hit && pend_valid_q && !out_free;
  assign scan_end = !chk_valid_q && (issue_q == ECW'(twtt_pkg::TIMER_ENTRIES));

  assign tick_next = {1'b0, cur_q} + SW'(1);

  // A remainder of zero stands for a full turn; the pointer is below the slot count,
  // so one conditional subtraction wraps the sum.
  assign add_d   = (div_rsp.rem == '0) ? sc : {1'b0, div_rsp.rem};
  assign add_sum = {1'b0, cur_q} + add_d;

  assign st_idle   = (state_q == twtt_pkg::ST_IDLE);
  assign st_tick   = (state_q == twtt_pkg::ST_SCAN) || (state_q == twtt_pkg::ST_FLUSH);
  assign st_div    = (state_q == twtt_pkg::ST_DIV);
  assign hit_taken = (state_q == twtt_pkg::ST_SCAN) && hit && !blocked;

  twtt_rem_unit u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (sc),
    .rsp_o     (div_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      twtt_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req_i.cmd)
            twtt_pkg::CMD_ADD: begin
              if (id_ok) begin
                state_d = twtt_pkg::ST_DIV;
              end
            end
            twtt_pkg::CMD_REFRESH: begin
              if (id_ok && armed_q[in_req_i.timer_id]) begin
                state_d = twtt_pkg::ST_RD;
              end
            end
            twtt_pkg::CMD_TICK: begin
              state_d = twtt_pkg::ST_SCAN;
            end
            default: begin
              state_d = twtt_pkg::ST_IDLE;
            end
          endcase
        end
      end
      twtt_pkg::ST_REDUCE: begin
        if ({1'b0, cur_q} < sc) begin
          state_d = twtt_pkg::ST_IDLE;
        end
      end
      twtt_pkg::ST_RD: begin
        state_d = twtt_pkg::ST_DIV;
      end
      twtt_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = twtt_pkg::ST_IDLE;
        end
      end
      twtt_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = twtt_pkg::ST_FLUSH;
        end
      end
      twtt_pkg::ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = twtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = twtt_pkg::ST_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      state_d = twtt_pkg::ST_REDUCE;
    end
  end

  // Outputs and datapath.
  always_comb begin
    in_stall_o   = (state_q != twtt_pkg::ST_IDLE);
    slots_d      = slots_q;
    cur_d        = cur_q;
    armed_d      = armed_q;
    is_refresh_d = is_refresh_q;
    id_d         = id_q;
    dly_d        = dly_q;
    issue_d      = issue_q;
    chk_valid_d  = chk_valid_q;
    chk_idx_d    = chk_idx_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_rsp_d    = out_rsp_q;
    mem_we       = 1'b0;
    mem_waddr    = id_q;
    mem_wdata    = '{expiry: add_sum[CUR_W-1:0], delay: add_d};
    mem_re       = 1'b0;
    mem_raddr    = in_req_i.timer_id;
    div_req      = '{start: 1'b0, dividend: in_req_i.delay_ticks};

    case (state_q)
      twtt_pkg::ST_IDLE: begin
        if (accept) begin
          id_d = in_req_i.timer_id;
          case (in_req_i.cmd)
            twtt_pkg::CMD_ADD: begin
              if (id_ok) begin
                is_refresh_d  = 1'b0;
                div_req.start = 1'b1;
              end
            end
            twtt_pkg::CMD_REFRESH: begin
              if (id_ok && armed_q[in_req_i.timer_id]) begin
                is_refresh_d = 1'b1;
                mem_re       = 1'b1;
              end
            end
            twtt_pkg::CMD_TICK: begin
              if (tick_next >= sc) begin
                cur_d = '0;
              end else begin
                cur_d = tick_next[CUR_W-1:0];
              end
              issue_d      = '0;
              chk_valid_d  = 1'b0;
              pend_valid_d = 1'b0;
            end
            default: begin
              id_d = id_q;
            end
          endcase
        end
      end
      twtt_pkg::ST_REDUCE: begin
        if ({1'b0, cur_q} >= sc) begin
          cur_d = CUR_W'({1'b0, cur_q} - sc);
        end
      end
      twtt_pkg::ST_RD: begin
        // The refreshed timer restarts from the pointer with its stored delay.
        dly_d            = rdata_q.delay;
        div_req.start    = 1'b1;
        div_req.dividend = twtt_pkg::DELAY_W'({1'b0, cur_q} + {1'b0, rdata_q.delay});
      end
      twtt_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          mem_we = 1'b1;
          if (is_refresh_q) begin
            mem_wdata = '{expiry: div_rsp.rem, delay: dly_q};
          end else begin
            if (add_sum >= sc) begin
              mem_wdata.expiry = CUR_W'(add_sum - sc);
            end
            armed_d[id_q] = 1'b1;
          end
        end
      end
      twtt_pkg::ST_SCAN: begin
        if (!blocked) begin
          if (hit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_rsp_d   = '{expired_id: pend_id_q, last_expired: 1'b0};
            end
            pend_valid_d       = 1'b1;
            pend_id_d          = chk_idx_q;
            armed_d[chk_idx_q] = 1'b0;
          end
          if (issue_q < ECW'(twtt_pkg::TIMER_ENTRIES)) begin
            mem_re      = 1'b1;
            mem_raddr   = issue_q[ID_W-1:0];
            chk_valid_d = 1'b1;
            chk_idx_d   = issue_q[ID_W-1:0];
            issue_d     = issue_q + ECW'(1);
          end else begin
            chk_valid_d = 1'b0;
          end
        end
      end
      twtt_pkg::ST_FLUSH: begin
        // The match still held back is the final one of this tick.
        if (pend_valid_q && out_free) begin
          out_valid_d  = 1'b1;
          out_rsp_d    = '{expired_id: pend_id_q, last_expired: 1'b1};
          pend_valid_d = 1'b0;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase

    if (cfg_we_i) begin
      slots_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= twtt_pkg::ST_IDLE;
      slots_q      <= twtt_pkg::SLOT_RESET;
      cur_q        <= '0;
      armed_q      <= '0;
      chk_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      issue_q      <= '0;
      is_refresh_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      slots_q      <= slots_d;
      cur_q        <= cur_d;
      armed_q      <= armed_d;
      chk_valid_q  <= chk_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      issue_q      <= issue_d;
      is_refresh_q <= is_refresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    dly_q     <= dly_d;
    chk_idx_q <= chk_idx_d;
    pend_id_q <= pend_id_d;
    out_rsp_q <= out_rsp_d;
  end

  // Entry memory: expiry slot and effective delay of each timer.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The pointer is on the wheel whenever commands are taken.
  `TWTT_ASSERT(a_cur_on_wheel, st_idle |-> ({1'b0, cur_q} < sc), "pointer off the wheel")
  // A held-back match only exists during a tick.
  `TWTT_ASSERT(a_pend_in_tick, pend_valid_q |-> st_tick, "pending expiry outside a tick")
  // The remainder unit only runs on behalf of an add or a refresh.
  `TWTT_ASSERT_NEVER(a_div_idle, div_rsp.busy && !st_div, "remainder unit busy out of turn")
  // A reported timer is disarmed.
  `TWTT_ASSERT(a_hit_disarms, hit_taken |=> !armed_q[$past(chk_idx_q)], "expired timer armed")

endmodule

// ===== sim/timing_wheel_timeout_table_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the timing wheel timeout table: watches the request, result and
// configuration ports, predicts every expiry and compares the results in order.
// Depends on twtt_pkg for the payload types, widths and command codes.
module timing_wheel_timeout_table_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  twtt_pkg::twtt_req_t          in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  twtt_pkg::twtt_rsp_t          out_rsp_i,
  input  logic                         cfg_we_i,
  input  logic [twtt_pkg::SLOT_W-1:0]  cfg_wdata_i,
  output int                           mismatch_count_o,
  output int                           expiries_due_o
);

  logic                         timer_armed [twtt_pkg::TIMER_ENTRIES];
  logic [twtt_pkg::CUR_W-1:0]   timer_slot  [twtt_pkg::TIMER_ENTRIES];
  logic [twtt_pkg::SLOT_W-1:0]  timer_span  [twtt_pkg::TIMER_ENTRIES];
  logic [twtt_pkg::CUR_W-1:0]   wheel_pos;
  logic [twtt_pkg::SLOT_W-1:0]  wheel_raw;
  twtt_pkg::twtt_rsp_t          expiry_q[$];
  int                           mismatch_count = 0;
  int                           due_count = 0;

  assign mismatch_count_o = mismatch_count;
  assign expiries_due_o   = due_count;

  // Slot count in force: a zero register acts as one slot, anything above 64 as 64.
  function automatic int unsigned wheel_size(input logic [twtt_pkg::SLOT_W-1:0] raw);
    int unsigned n;
    n = raw;
    if (n == 0) begin
      n = 1;
    end else if (n > 64) begin
      n = 64;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] expiry mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic predict_request(input twtt_pkg::twtt_req_t req);
    int unsigned         n;
    int unsigned         d;
    int unsigned         next_pos;
    int                  last_id;
    twtt_pkg::twtt_rsp_t fired;
    n = wheel_size(wheel_raw);
    case (req.cmd)
      twtt_pkg::CMD_ADD: begin
        d = req.delay_ticks % n;
        if (d == 0) begin
          d = n;
        end
        timer_span[req.timer_id]  = twtt_pkg::SLOT_W'(d);
        timer_slot[req.timer_id]  = twtt_pkg::CUR_W'((wheel_pos + d) % n);
        timer_armed[req.timer_id] = 1'b1;
      end
      twtt_pkg::CMD_REFRESH: begin
        if (timer_armed[req.timer_id]) begin
          timer_slot[req.timer_id] =
              twtt_pkg::CUR_W'((wheel_pos + timer_span[req.timer_id]) % n);
        end
      end
      twtt_pkg::CMD_TICK: begin
        next_pos  = wheel_pos + 1;
        wheel_pos = (next_pos >= n) ? '0 : twtt_pkg::CUR_W'(next_pos);
        last_id   = -1;
        for (int i = 0; i < twtt_pkg::TIMER_ENTRIES; i++) begin
          if (timer_armed[i] && timer_slot[i] == wheel_pos) begin
            last_id = i;
          end
        end
        for (int i = 0; i < twtt_pkg::TIMER_ENTRIES; i++) begin
          if (timer_armed[i] && timer_slot[i] == wheel_pos) begin
            fired.expired_id   = twtt_pkg::ID_W'(i);
            fired.last_expired = (i == last_id);
            expiry_q           = {expiry_q, fired};
            timer_armed[i]     = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_expiry(input twtt_pkg::twtt_rsp_t got);
    twtt_pkg::twtt_rsp_t want;
    if (expiry_q.size() == 0) begin
      report_mismatch($sformatf("expiry of id %0d with none outstanding", got.expired_id));
    end else begin
      want = expiry_q.pop_front();
      if (got.expired_id !== want.expired_id) begin
        report_mismatch($sformatf("expired_id %0d, predicted %0d",
                                  got.expired_id, want.expired_id));
      end
      if (got.last_expired !== want.last_expired) begin
        report_mismatch($sformatf("last_expired %b on id %0d, predicted %b",
                                  got.last_expired, want.expired_id, want.last_expired));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < twtt_pkg::TIMER_ENTRIES; i++) begin
        timer_armed[i] = 1'b0;
        timer_slot[i]  = '0;
        timer_span[i]  = '0;
      end
      wheel_pos = '0;
      wheel_raw = twtt_pkg::SLOT_RESET;
      expiry_q.delete();
      due_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_expiry(out_rsp_i);
      end
      if (cfg_we_i) begin
        wheel_raw = cfg_wdata_i;
        wheel_pos = twtt_pkg::CUR_W'(wheel_pos % wheel_size(cfg_wdata_i));
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(in_req_i);
      end
      due_count = expiry_q.size();
    end
  end

endmodule

// ===== sim/timing_wheel_timeout_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the timing wheel timeout table: clock, reset, request and
// result stimulus, wheel size writes and the final verdict.
// Depends on twtt_pkg, the block itself and timing_wheel_timeout_table_checker.
module timing_wheel_timeout_table_tb;

  localparam int         CLK_PERIOD    = 20;
  localparam int         RESET_CYCLES  = 7;
  // This comfortably covers any work still under way once nothing is outstanding,
  // be it a tick, an add, a refresh or a wheel write.
  localparam int         SETTLE_CYCLES = 120;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         QUIET_LIMIT   = 4000;
  localparam int         PHASE_ITEMS   = 18;
  localparam int         PHASES        = 8;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  twtt_pkg::twtt_req_t          in_req_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  twtt_pkg::twtt_rsp_t          out_rsp_o;
  logic                         cfg_we_i;
  logic [twtt_pkg::SLOT_W-1:0]  cfg_wdata_i;

  int                           mismatches;
  int                           expiries_due;
  int                           send_idle_pct  = 30;
  int                           recv_stall_pct = 78;
  logic                         rx_hold        = 1'b0;
  event                         hold_off_ev;
  int                           recent_ids[$];
  logic [twtt_pkg::SLOT_W-1:0]  wheel_setting  = twtt_pkg::SLOT_RESET;

  // Wheel sizes visited in turn. The first grows to the clamp, the second shrinks
  // so that some timers are stranded off the wheel, the third grows again so they
  // come back, and the zero setting acts as a one-slot wheel where every armed
  // timer fires on every tick.
  logic [twtt_pkg::SLOT_W-1:0] wheel_plan [PHASES] = '{7'd127, 7'd9, 7'd64, 7'd0,
                                                       7'd3, 7'd1, 7'd60, 7'd2};

  timing_wheel_timeout_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  timing_wheel_timeout_table_checker expiry_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_req_i         (in_req_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_rsp_i        (out_rsp_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .expiries_due_o   (expiries_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // The result side stalls at random at the falling edge, or solidly while a
  // hold-off is in progress.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = rx_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The long hold-off: the result side refuses everything until the count kept here
  // runs out, while requests keep coming so that the block backs up and stalls its
  // request side.
  initial begin
    @(hold_off_ev);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // Watchdog: any cycle in which a request, a result or a wheel write goes
  // through restarts the count; a long silence means the block has hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic twtt_pkg::twtt_req_t make_req(input logic [1:0] cmd, input int id,
                                                   input logic [twtt_pkg::DELAY_W-1:0] delay);
    twtt_pkg::twtt_req_t req;
    req.cmd         = cmd;
    req.timer_id    = twtt_pkg::ID_W'(id);
    req.delay_ticks = delay;
    return req;
  endfunction

  // Mostly well-formed traffic: adds with delays near the wheel size, refreshes
  // that usually hit a recently added timer, and plenty of ticks to retire them.
  // The remainder is refreshes of random ids and the unused command code.
  function automatic twtt_pkg::twtt_req_t random_request();
    twtt_pkg::twtt_req_t req;
    int                  roll;
    roll            = $urandom_range(99);
    req.timer_id    = twtt_pkg::ID_W'($urandom_range(twtt_pkg::TIMER_ENTRIES - 1));
    req.delay_ticks = $urandom;
    if (roll < 35) begin
      req.cmd = twtt_pkg::CMD_ADD;
      case ($urandom_range(3))
        0, 1: req.delay_ticks = $urandom_range(2 * int'(wheel_setting) + 2);
        2: begin
        end
        default: begin
          case ($urandom_range(3))
            0: req.delay_ticks = '0;
            1: req.delay_ticks = '1;
            2: req.delay_ticks = twtt_pkg::DELAY_W'(wheel_setting);
            default: req.delay_ticks = 32'hFFFF_FFFF - $urandom_range(3);
          endcase
        end
      endcase
      recent_ids = {recent_ids, int'(req.timer_id)};
      if (recent_ids.size() > 12) begin
        void'(recent_ids.pop_front());
      end
    end else if (roll < 55) begin
      req.cmd = twtt_pkg::CMD_REFRESH;
      if (recent_ids.size() > 0 && $urandom_range(3) != 0) begin
        req.timer_id = twtt_pkg::ID_W'(recent_ids[$urandom_range(recent_ids.size() - 1)]);
      end
    end else if (roll < 95) begin
      req.cmd = twtt_pkg::CMD_TICK;
    end else begin
      req.cmd = CMD_UNUSED;
    end
    return req;
  endfunction

  // Presents one request from a falling edge and returns at the falling edge
  // after it has been taken, with valid still high so that a following request
  // can go straight out without a bubble.
  task automatic offer(input twtt_pkg::twtt_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Lets every outstanding expiry come back, then allows for an add or refresh
  // still being worked on, since those produce nothing to wait for.
  task automatic wait_quiet();
    in_valid_i = 1'b0;
    while (expiries_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int fill_order [twtt_pkg::TIMER_ENTRIES];
    int pick;
    int swap;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part on the 60-slot wheel left by reset. A zero delay means a full
    // turn, the all-ones delay exercises the wide remainder, and id 5 is re-added
    // while live so that only its new expiry may be reported.
    offer(make_req(twtt_pkg::CMD_ADD, 0, 32'd0));
    offer(make_req(twtt_pkg::CMD_ADD, 63, 32'hFFFF_FFFF));
    offer(make_req(twtt_pkg::CMD_ADD, 5, 32'd1));
    offer(make_req(twtt_pkg::CMD_ADD, 5, 32'd2));
    offer(make_req(twtt_pkg::CMD_REFRESH, 5, 32'hFFFF_FFFF));
    // A refresh of an id that was never armed and the unused code change nothing.
    offer(make_req(twtt_pkg::CMD_REFRESH, 40, 32'd0));
    offer(make_req(CMD_UNUSED, 21, 32'hAAAA_5555));
    // Three timers due on the same tick, added out of order, must come back in
    // ascending id order with the last flag on the final one.
    offer(make_req(twtt_pkg::CMD_ADD, 10, 32'd61));
    offer(make_req(twtt_pkg::CMD_ADD, 3, 32'd1));
    offer(make_req(twtt_pkg::CMD_ADD, 62, 32'd121));
    offer(make_req(twtt_pkg::CMD_TICK, 0, 32'd0));
    offer(make_req(twtt_pkg::CMD_TICK, 63, 32'h5555_AAAA));
    offer(make_req(twtt_pkg::CMD_TICK, 42, 32'h0000_FFFF));
    // Id 5 has just fired, so refreshing it now is a refresh of an unknown id.
    offer(make_req(twtt_pkg::CMD_REFRESH, 5, 32'd7));
    offer(make_req(twtt_pkg::CMD_ADD, 33, 32'd59));
    offer(make_req(twtt_pkg::CMD_TICK, 17, 32'hFFFF_0000));
    offer(make_req(twtt_pkg::CMD_REFRESH, 33, 32'd0));
    offer(make_req(twtt_pkg::CMD_ADD, 33, 32'd3));
    repeat (3) offer(make_req(twtt_pkg::CMD_TICK, 0, 32'd0));

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      // Sender idles lightly and receiver heavily first, then the other way
      // round, and the last phases run with no idling on either side.
      if (p < 3) begin
        send_idle_pct  = 30;
        recv_stall_pct = 78;
      end else if (p < 6) begin
        send_idle_pct  = 78;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      cfg_we_i      = 1'b1;
      cfg_wdata_i   = wheel_plan[p];
      wheel_setting = wheel_plan[p];
      @(negedge clk_i);
      cfg_we_i = 1'b0;
      recent_ids.delete();

      if (wheel_plan[p] == '0) begin
        // One-slot wheel: arm every timer in a shuffled order so that a single
        // tick reports all of them, then hold the result side off while the
        // request side keeps offering, which backs the whole block up.
        for (int i = 0; i < twtt_pkg::TIMER_ENTRIES; i++) begin
          fill_order[i] = i;
        end
        for (int i = twtt_pkg::TIMER_ENTRIES - 1; i > 0; i--) begin
          pick             = $urandom_range(i);
          swap             = fill_order[i];
          fill_order[i]    = fill_order[pick];
          fill_order[pick] = swap;
        end
        for (int i = 0; i < twtt_pkg::TIMER_ENTRIES; i++) begin
          offer(make_req(twtt_pkg::CMD_ADD, fill_order[i], $urandom));
        end
        -> hold_off_ev;
        offer(make_req(twtt_pkg::CMD_TICK, 0, 32'd0));
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        offer(random_request());
      end
    end

    wait_quiet();
    if (mismatches == 0 && expiries_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/twtt_pkg.sv
rtl/twtt_rem_unit.sv
rtl/timing_wheel_timeout_table.sv
sim/timing_wheel_timeout_table_checker.sv
sim/timing_wheel_timeout_table_tb.sv
